@@ rtl/core/wdrh_pkg.sv @@
package wdrh_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ID_W        = 10;
  localparam int SLOT_W      = 10;
  localparam int CNT_W       = 11;
  localparam int DL_W        = 64;
  localparam int W_W         = 32;

  typedef enum logic [2:0] {
    OP_ENQ     = 3'd0,
    OP_DEQ     = 3'd1,
    OP_REQ     = 3'd2,
    OP_QUERY   = 3'd3,
    OP_ACT     = 3'd4,
    OP_SETIDLE = 3'd5,
    OP_REFILL  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]      operation;
    logic [ID_W-1:0] entry_id;
    logic [DL_W-1:0] deadline_in;
    logic [DL_W-1:0] budget_in;
    logic [W_W-1:0]  weight_in;
    logic [DL_W-1:0] quantum_in;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  chosen_entry;
    logic             chosen_is_idle;
    logic [DL_W-1:0]  deadline_out;
    logic [DL_W-1:0]  budget_out;
    logic [CNT_W-1:0] queue_count;
  } rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDID, S_DECODE,
    S_DQ_HS, S_DQ_DL, S_DQ_D,
    S_Q_DL, S_Q_OUT, S_Q_CPY,
    S_REORD, S_STORE,
    S_RF_DA, S_RF_M0, S_RF_M1, S_RF_SUM, S_RF_ADD, S_RF_FIN,
    S_UP_CHK, S_UP_DL, S_UP_CMP,
    S_DN_CHK, S_DN_H2, S_DN_D2, S_DN_SEL, S_DN_CMP,
    S_FINAL, S_DONE
  } st_t;

  typedef enum logic [5:0] {
    C_NOP, C_CLR, C_ACCEPT, C_RDID, C_IGN, C_FULL, C_INS, C_DEQ,
    C_DQ_HS, C_DQ_DL, C_DQ_D, C_REQ_IGN, C_REORD, C_STORE,
    C_Q_HS, C_Q_DL, C_Q_OUT, C_Q_CUR, C_Q_CPY, C_Q_IDL, C_Q_NONE,
    C_ACT, C_SETIDLE,
    C_RF_RD, C_RF_DA, C_RF_M0, C_RF_M1, C_RF_SUM, C_RF_ADD, C_RF_FIN,
    C_UP_RD, C_UP_DL, C_UP_SWAP,
    C_DN_RD1, C_DN_H2, C_DN_D2, C_DN_SEL, C_DN_SWAP,
    C_FINAL
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       queued;
    logic       idle_hit;
    logic       full;
    logic       cnt_zero;
    logic       idle_v;
    logic       cur_v;
    logic       deq_move;
    logic       pos_zero;
    logic       strict;
    logic       up_swap;
    logic       dn_leaf;
    logic       dn_stop;
    logic       clr_last;
  } sts_t;

endpackage

@@ rtl/core/wdrh_ctrl.sv @@
module wdrh_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  wdrh_pkg::sts_t sts,
  output wdrh_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  wdrh_pkg::st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wdrh_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      wdrh_pkg::S_CLEAR: if (sts.clr_last) state_next = wdrh_pkg::S_IDLE;
      wdrh_pkg::S_IDLE: if (start) state_next = wdrh_pkg::S_RDID;
      wdrh_pkg::S_RDID: state_next = wdrh_pkg::S_DECODE;
      wdrh_pkg::S_DECODE: begin
        unique case (sts.op)
          wdrh_pkg::OP_ENQ: begin
            if (sts.queued || sts.idle_hit || sts.full) state_next = wdrh_pkg::S_DONE;
            else state_next = wdrh_pkg::S_UP_CHK;
          end
          wdrh_pkg::OP_DEQ: begin
            if (!sts.queued || sts.idle_hit || !sts.deq_move) state_next = wdrh_pkg::S_DONE;
            else state_next = wdrh_pkg::S_DQ_HS;
          end
          wdrh_pkg::OP_REQ: begin
            priority if (sts.idle_hit) state_next = wdrh_pkg::S_DONE;
            else if (sts.queued) state_next = wdrh_pkg::S_UP_CHK;
            else if (sts.full) state_next = wdrh_pkg::S_DONE;
            else state_next = wdrh_pkg::S_UP_CHK;
          end
          wdrh_pkg::OP_QUERY: begin
            priority if (!sts.cnt_zero) state_next = wdrh_pkg::S_Q_DL;
            else if (sts.idle_v && sts.cur_v) state_next = wdrh_pkg::S_Q_CPY;
            else if (sts.idle_v) state_next = wdrh_pkg::S_Q_OUT;
            else state_next = wdrh_pkg::S_DONE;
          end
          wdrh_pkg::OP_ACT: begin
            if (sts.queued) state_next = wdrh_pkg::S_REORD;
            else state_next = wdrh_pkg::S_DONE;
          end
          wdrh_pkg::OP_REFILL: state_next = wdrh_pkg::S_RF_DA;
          default: state_next = wdrh_pkg::S_DONE;
        endcase
      end
      wdrh_pkg::S_DQ_HS: state_next = wdrh_pkg::S_DQ_DL;
      wdrh_pkg::S_DQ_DL: state_next = wdrh_pkg::S_DQ_D;
      wdrh_pkg::S_DQ_D: state_next = wdrh_pkg::S_UP_CHK;
      wdrh_pkg::S_Q_DL: state_next = wdrh_pkg::S_Q_OUT;
      wdrh_pkg::S_Q_OUT: state_next = wdrh_pkg::S_DONE;
      wdrh_pkg::S_Q_CPY: state_next = wdrh_pkg::S_DONE;
      wdrh_pkg::S_REORD: state_next = wdrh_pkg::S_UP_CHK;
      wdrh_pkg::S_STORE: state_next = wdrh_pkg::S_DONE;
      wdrh_pkg::S_RF_DA: state_next = wdrh_pkg::S_RF_M0;
      wdrh_pkg::S_RF_M0: state_next = wdrh_pkg::S_RF_M1;
      wdrh_pkg::S_RF_M1: state_next = wdrh_pkg::S_RF_SUM;
      wdrh_pkg::S_RF_SUM: state_next = wdrh_pkg::S_RF_ADD;
      wdrh_pkg::S_RF_ADD: state_next = wdrh_pkg::S_RF_FIN;
      wdrh_pkg::S_RF_FIN: begin
        if (sts.queued) state_next = wdrh_pkg::S_REORD;
        else state_next = wdrh_pkg::S_STORE;
      end
      wdrh_pkg::S_UP_CHK: begin
        priority if (!sts.pos_zero) state_next = wdrh_pkg::S_UP_DL;
        else if (sts.strict) state_next = wdrh_pkg::S_DN_CHK;
        else state_next = wdrh_pkg::S_FINAL;
      end
      wdrh_pkg::S_UP_DL: state_next = wdrh_pkg::S_UP_CMP;
      wdrh_pkg::S_UP_CMP: begin
        priority if (sts.up_swap) state_next = wdrh_pkg::S_UP_CHK;
        else if (sts.strict) state_next = wdrh_pkg::S_DN_CHK;
        else state_next = wdrh_pkg::S_FINAL;
      end
      wdrh_pkg::S_DN_CHK: begin
        if (sts.dn_leaf) state_next = wdrh_pkg::S_FINAL;
        else state_next = wdrh_pkg::S_DN_H2;
      end
      wdrh_pkg::S_DN_H2: state_next = wdrh_pkg::S_DN_D2;
      wdrh_pkg::S_DN_D2: state_next = wdrh_pkg::S_DN_SEL;
      wdrh_pkg::S_DN_SEL: state_next = wdrh_pkg::S_DN_CMP;
      wdrh_pkg::S_DN_CMP: begin
        if (sts.dn_stop) state_next = wdrh_pkg::S_FINAL;
        else state_next = wdrh_pkg::S_DN_CHK;
      end
      wdrh_pkg::S_FINAL: state_next = wdrh_pkg::S_DONE;
      wdrh_pkg::S_DONE: state_next = wdrh_pkg::S_IDLE;
      default: state_next = wdrh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = wdrh_pkg::C_NOP;
    busy = (state != wdrh_pkg::S_IDLE);
    done = (state == wdrh_pkg::S_DONE);
    unique case (state)
      wdrh_pkg::S_CLEAR: cmd = wdrh_pkg::C_CLR;
      wdrh_pkg::S_IDLE: if (start) cmd = wdrh_pkg::C_ACCEPT;
      wdrh_pkg::S_RDID: cmd = wdrh_pkg::C_RDID;
      wdrh_pkg::S_DECODE: begin
        unique case (sts.op)
          wdrh_pkg::OP_ENQ: begin
            priority if (sts.queued || sts.idle_hit) cmd = wdrh_pkg::C_IGN;
            else if (sts.full) cmd = wdrh_pkg::C_FULL;
            else cmd = wdrh_pkg::C_INS;
          end
          wdrh_pkg::OP_DEQ: begin
            if (!sts.queued || sts.idle_hit) cmd = wdrh_pkg::C_IGN;
            else cmd = wdrh_pkg::C_DEQ;
          end
          wdrh_pkg::OP_REQ: begin
            priority if (sts.idle_hit) cmd = wdrh_pkg::C_REQ_IGN;
            else if (sts.queued) cmd = wdrh_pkg::C_REORD;
            else if (sts.full) cmd = wdrh_pkg::C_FULL;
            else cmd = wdrh_pkg::C_INS;
          end
          wdrh_pkg::OP_QUERY: begin
            priority if (!sts.cnt_zero) cmd = wdrh_pkg::C_Q_HS;
            else if (sts.idle_v && sts.cur_v) cmd = wdrh_pkg::C_Q_CUR;
            else if (sts.idle_v) cmd = wdrh_pkg::C_Q_IDL;
            else cmd = wdrh_pkg::C_Q_NONE;
          end
          wdrh_pkg::OP_ACT: cmd = wdrh_pkg::C_ACT;
          wdrh_pkg::OP_SETIDLE: begin
            if (sts.queued) cmd = wdrh_pkg::C_IGN;
            else cmd = wdrh_pkg::C_SETIDLE;
          end
          wdrh_pkg::OP_REFILL: cmd = wdrh_pkg::C_RF_RD;
          default: cmd = wdrh_pkg::C_IGN;
        endcase
      end
      wdrh_pkg::S_DQ_HS: cmd = wdrh_pkg::C_DQ_HS;
      wdrh_pkg::S_DQ_DL: cmd = wdrh_pkg::C_DQ_DL;
      wdrh_pkg::S_DQ_D: cmd = wdrh_pkg::C_DQ_D;
      wdrh_pkg::S_Q_DL: cmd = wdrh_pkg::C_Q_DL;
      wdrh_pkg::S_Q_OUT: cmd = wdrh_pkg::C_Q_OUT;
      wdrh_pkg::S_Q_CPY: cmd = wdrh_pkg::C_Q_CPY;
      wdrh_pkg::S_REORD: cmd = wdrh_pkg::C_REORD;
      wdrh_pkg::S_STORE: cmd = wdrh_pkg::C_STORE;
      wdrh_pkg::S_RF_DA: cmd = wdrh_pkg::C_RF_DA;
      wdrh_pkg::S_RF_M0: cmd = wdrh_pkg::C_RF_M0;
      wdrh_pkg::S_RF_M1: cmd = wdrh_pkg::C_RF_M1;
      wdrh_pkg::S_RF_SUM: cmd = wdrh_pkg::C_RF_SUM;
      wdrh_pkg::S_RF_ADD: cmd = wdrh_pkg::C_RF_ADD;
      wdrh_pkg::S_RF_FIN: cmd = wdrh_pkg::C_RF_FIN;
      wdrh_pkg::S_UP_CHK: if (!sts.pos_zero) cmd = wdrh_pkg::C_UP_RD;
      wdrh_pkg::S_UP_DL: cmd = wdrh_pkg::C_UP_DL;
      wdrh_pkg::S_UP_CMP: if (sts.up_swap) cmd = wdrh_pkg::C_UP_SWAP;
      wdrh_pkg::S_DN_CHK: if (!sts.dn_leaf) cmd = wdrh_pkg::C_DN_RD1;
      wdrh_pkg::S_DN_H2: cmd = wdrh_pkg::C_DN_H2;
      wdrh_pkg::S_DN_D2: cmd = wdrh_pkg::C_DN_D2;
      wdrh_pkg::S_DN_SEL: cmd = wdrh_pkg::C_DN_SEL;
      wdrh_pkg::S_DN_CMP: if (!sts.dn_stop) cmd = wdrh_pkg::C_DN_SWAP;
      wdrh_pkg::S_FINAL: cmd = wdrh_pkg::C_FINAL;
      wdrh_pkg::S_DONE: cmd = wdrh_pkg::C_NOP;
      default: cmd = wdrh_pkg::C_NOP;
    endcase
  end

endmodule

@@ rtl/core/wdrh_dpath.sv @@
module wdrh_dpath (
  input  logic           clk,
  input  logic           rst,
  input  wdrh_pkg::cmd_t cmd,
  input  wdrh_pkg::req_t request,
  output wdrh_pkg::sts_t sts,
  output wdrh_pkg::rsp_t result
);

  localparam int ID_W   = wdrh_pkg::ID_W;
  localparam int SLOT_W = wdrh_pkg::SLOT_W;
  localparam int CNT_W  = wdrh_pkg::CNT_W;
  localparam int DL_W   = wdrh_pkg::DL_W;
  localparam int W_W    = wdrh_pkg::W_W;
  localparam int NUM_ID = 1 << ID_W;

  logic [ID_W-1:0]   hs_mem [wdrh_pkg::MAX_ENTRIES];
  logic [DL_W-1:0]   dl_mem [NUM_ID];
  logic [SLOT_W-1:0] se_mem [NUM_ID];
  logic              eq_mem [NUM_ID];

  logic [ID_W-1:0]   hs_q;
  logic [DL_W-1:0]   dl_q;
  logic [SLOT_W-1:0] se_q;
  logic              eq_q;

  wdrh_pkg::req_t    req;
  logic [1:0]        r_status;
  logic [ID_W-1:0]   r_chosen;
  logic              r_is_idle;
  logic [DL_W-1:0]   r_dl;
  logic [DL_W-1:0]   r_budget;

  logic [CNT_W-1:0]  cnt;
  logic [ID_W-1:0]   idle_e;
  logic              idle_v;
  logic [ID_W-1:0]   cur_e;
  logic              cur_v;
  logic [ID_W-1:0]   clr_addr;

  logic [SLOT_W-1:0] pos;
  logic [SLOT_W-1:0] nb_pos;
  logic [ID_W-1:0]   mv_e;
  logic [DL_W-1:0]   mv_d;
  logic [ID_W-1:0]   nb_e;
  logic [DL_W-1:0]   nb_d;
  logic [ID_W-1:0]   c2_e;
  logic              strict;
  logic [DL_W-1:0]   nd;
  logic [DL_W-1:0]   da;
  logic [DL_W-1:0]   diff;
  logic              lag;
  logic [DL_W-1:0]   p_lo;
  logic [DL_W-1:0]   p_hi;
  logic [DL_W-1:0]   addv;
  logic [DL_W-1:0]   bsum;

  logic [SLOT_W-1:0] parent;
  logic [SLOT_W-1:0] pos_m1;
  logic [SLOT_W+1:0] c1;
  logic [SLOT_W+1:0] c2;
  logic              has_c2;
  logic [W_W-1:0]    mul_a;
  logic [DL_W-1:0]   mul_p;
  logic [DL_W+W_W-1:0] sum96;
  logic [DL_W:0]     badd;
  logic [DL_W-1:0]   da_sel;

  logic              hs_re, dl_re;
  logic [SLOT_W-1:0] hs_ra;
  logic [ID_W-1:0]   dl_ra;
  logic              hs_we, se_we, dl_we, eq_we;
  logic [SLOT_W-1:0] hs_wa;
  logic [ID_W-1:0]   hs_wd;
  logic [ID_W-1:0]   se_wa;
  logic [SLOT_W-1:0] se_wd;
  logic [ID_W-1:0]   dl_wa;
  logic [DL_W-1:0]   dl_wd;
  logic [ID_W-1:0]   eq_wa;
  logic              eq_wd;

  assign pos_m1 = pos - SLOT_W'(1);
  assign parent = {1'b0, pos_m1[SLOT_W-1:1]};
  assign c1     = {1'b0, pos, 1'b1};
  assign c2     = c1 + (SLOT_W+2)'(1);
  assign has_c2 = {1'b0, cnt} > c2;
  assign mul_a  = (cmd == wdrh_pkg::C_RF_M0) ? diff[W_W-1:0] : diff[DL_W-1:W_W];
  assign mul_p  = DL_W'(mul_a) * DL_W'(req.weight_in);
  assign sum96  = {p_hi, {W_W{1'b0}}} + (DL_W+W_W)'(p_lo);
  assign badd   = {1'b0, req.budget_in} + {1'b0, addv};
  assign da_sel = cur_v ? dl_q : '0;

  always_comb begin
    hs_re = 1'b1;
    hs_ra = '0;
    unique case (cmd)
      wdrh_pkg::C_Q_HS:   hs_ra = '0;
      wdrh_pkg::C_DQ_HS:  hs_ra = cnt[SLOT_W-1:0];
      wdrh_pkg::C_UP_RD:  hs_ra = parent;
      wdrh_pkg::C_DN_RD1: hs_ra = c1[SLOT_W-1:0];
      wdrh_pkg::C_DN_H2:  hs_ra = c2[SLOT_W-1:0];
      default:            hs_re = 1'b0;
    endcase
  end

  always_comb begin
    dl_re = 1'b1;
    dl_ra = hs_q;
    unique case (cmd)
      wdrh_pkg::C_DQ_DL, wdrh_pkg::C_UP_DL, wdrh_pkg::C_DN_H2,
      wdrh_pkg::C_DN_D2, wdrh_pkg::C_Q_DL: dl_ra = hs_q;
      wdrh_pkg::C_Q_CUR, wdrh_pkg::C_RF_RD: dl_ra = cur_e;
      wdrh_pkg::C_Q_IDL: dl_ra = idle_e;
      default: dl_re = 1'b0;
    endcase
  end

  always_comb begin
    hs_we = 1'b0;
    hs_wa = pos;
    hs_wd = nb_e;
    se_we = 1'b0;
    se_wa = nb_e;
    se_wd = pos;
    unique case (cmd)
      wdrh_pkg::C_UP_SWAP, wdrh_pkg::C_DN_SWAP: begin
        hs_we = 1'b1;
        se_we = 1'b1;
      end
      wdrh_pkg::C_FINAL: begin
        hs_we = 1'b1;
        se_we = 1'b1;
        hs_wd = mv_e;
        se_wa = mv_e;
      end
      default: ;
    endcase
  end

  always_comb begin
    dl_we = 1'b0;
    dl_wa = req.entry_id;
    dl_wd = nd;
    eq_we = 1'b0;
    eq_wa = req.entry_id;
    eq_wd = 1'b0;
    unique case (cmd)
      wdrh_pkg::C_INS: begin
        dl_we = 1'b1;
        eq_we = 1'b1;
        eq_wd = 1'b1;
      end
      wdrh_pkg::C_FULL, wdrh_pkg::C_REQ_IGN, wdrh_pkg::C_REORD,
      wdrh_pkg::C_ACT, wdrh_pkg::C_STORE: dl_we = 1'b1;
      wdrh_pkg::C_Q_CPY: begin
        dl_we = 1'b1;
        dl_wa = idle_e;
        dl_wd = dl_q;
      end
      wdrh_pkg::C_DEQ: eq_we = 1'b1;
      wdrh_pkg::C_CLR: begin
        eq_we = 1'b1;
        eq_wa = clr_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[hs_wa] <= hs_wd;
    if (hs_re) hs_q <= hs_mem[hs_ra];
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (dl_re) dl_q <= dl_mem[dl_ra];
  end

  always_ff @(posedge clk) begin
    if (se_we) se_mem[se_wa] <= se_wd;
    if (cmd == wdrh_pkg::C_RDID) se_q <= se_mem[req.entry_id];
  end

  always_ff @(posedge clk) begin
    if (eq_we) eq_mem[eq_wa] <= eq_wd;
    if (cmd == wdrh_pkg::C_RDID) eq_q <= eq_mem[req.entry_id];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      idle_e   <= '0;
      idle_v   <= 1'b0;
      cur_e    <= '0;
      cur_v    <= 1'b0;
      clr_addr <= '0;
    end else begin
      unique case (cmd)
        wdrh_pkg::C_CLR:     clr_addr <= clr_addr + ID_W'(1);
        wdrh_pkg::C_INS:     cnt <= cnt + CNT_W'(1);
        wdrh_pkg::C_DEQ:     cnt <= cnt - CNT_W'(1);
        wdrh_pkg::C_ACT: begin
          cur_e <= req.entry_id;
          cur_v <= 1'b1;
        end
        wdrh_pkg::C_SETIDLE: begin
          idle_e <= req.entry_id;
          idle_v <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      wdrh_pkg::C_ACCEPT: begin
        req       <= request;
        nd        <= request.deadline_in;
        r_status  <= wdrh_pkg::ST_DONE;
        r_chosen  <= request.entry_id;
        r_is_idle <= 1'b0;
        r_dl      <= '0;
        r_budget  <= '0;
      end
      wdrh_pkg::C_IGN, wdrh_pkg::C_REQ_IGN: r_status <= wdrh_pkg::ST_IGNORED;
      wdrh_pkg::C_FULL: r_status <= wdrh_pkg::ST_FULL;
      wdrh_pkg::C_INS: begin
        pos    <= cnt[SLOT_W-1:0];
        mv_e   <= req.entry_id;
        mv_d   <= nd;
        strict <= 1'b0;
      end
      wdrh_pkg::C_DEQ: pos <= se_q;
      wdrh_pkg::C_DQ_DL: mv_e <= hs_q;
      wdrh_pkg::C_DQ_D: begin
        mv_d   <= dl_q;
        strict <= 1'b1;
      end
      wdrh_pkg::C_REORD: begin
        pos    <= se_q;
        mv_e   <= req.entry_id;
        mv_d   <= nd;
        strict <= 1'b1;
      end
      wdrh_pkg::C_Q_DL: r_chosen <= hs_q;
      wdrh_pkg::C_Q_OUT, wdrh_pkg::C_Q_CPY: r_dl <= dl_q;
      wdrh_pkg::C_Q_CUR, wdrh_pkg::C_Q_IDL: begin
        r_chosen  <= idle_e;
        r_is_idle <= 1'b1;
      end
      wdrh_pkg::C_Q_NONE: begin
        r_chosen <= idle_e;
        r_status <= wdrh_pkg::ST_IGNORED;
      end
      wdrh_pkg::C_RF_DA: begin
        da   <= da_sel;
        lag  <= req.deadline_in < da_sel;
        diff <= da_sel - req.deadline_in;
      end
      wdrh_pkg::C_RF_M0: p_lo <= mul_p;
      wdrh_pkg::C_RF_M1: p_hi <= mul_p;
      wdrh_pkg::C_RF_SUM: addv <= (|sum96[DL_W+W_W-1:DL_W]) ? '1 : sum96[DL_W-1:0];
      wdrh_pkg::C_RF_ADD: bsum <= badd[DL_W] ? '1 : badd[DL_W-1:0];
      wdrh_pkg::C_RF_FIN: begin
        if (lag) begin
          nd       <= da;
          r_dl     <= da;
          r_budget <= (bsum > req.quantum_in) ? req.quantum_in : bsum;
        end else begin
          nd       <= req.deadline_in;
          r_dl     <= req.deadline_in;
          r_budget <= req.budget_in;
        end
      end
      wdrh_pkg::C_UP_DL: nb_e <= hs_q;
      wdrh_pkg::C_UP_SWAP: begin
        pos    <= parent;
        strict <= 1'b0;
      end
      wdrh_pkg::C_DN_H2: nb_e <= hs_q;
      wdrh_pkg::C_DN_D2: begin
        nb_d <= dl_q;
        c2_e <= hs_q;
      end
      wdrh_pkg::C_DN_SEL: begin
        if (has_c2 && (dl_q <= nb_d)) begin
          nb_e   <= c2_e;
          nb_d   <= dl_q;
          nb_pos <= c2[SLOT_W-1:0];
        end else begin
          nb_pos <= c1[SLOT_W-1:0];
        end
      end
      wdrh_pkg::C_DN_SWAP: pos <= nb_pos;
      default: ;
    endcase
  end

  always_comb begin
    sts.op       = req.operation;
    sts.queued   = eq_q;
    sts.idle_hit = idle_v && (idle_e == req.entry_id);
    sts.full     = (cnt == CNT_W'(wdrh_pkg::MAX_ENTRIES));
    sts.cnt_zero = (cnt == '0);
    sts.idle_v   = idle_v;
    sts.cur_v    = cur_v;
    sts.deq_move = (({1'b0, se_q} + CNT_W'(1)) < cnt);
    sts.pos_zero = (pos == '0);
    sts.strict   = strict;
    sts.up_swap  = strict ? (mv_d < dl_q) : !(dl_q < mv_d);
    sts.dn_leaf  = ({1'b0, cnt} <= c1);
    sts.dn_stop  = (mv_d <= nb_d);
    sts.clr_last = (clr_addr == '1);
  end

  always_comb begin
    result.status         = r_status;
    result.chosen_entry   = r_chosen;
    result.chosen_is_idle = r_is_idle;
    result.deadline_out   = r_dl;
    result.budget_out     = r_budget;
    result.queue_count    = cnt;
  end

endmodule

@@ rtl/core/wfq_deadline_ready_heap_top.sv @@
// Earliest-deadline ready heap. A request is taken when start is high and
// busy is low; its single result appears for exactly one cycle with done high
// and must be captured then, since the block cannot be stalled. A plain
// request reads its entry's flags, decodes and finishes. A heap walk has a
// check, a deadline read and a compare per parent going up, and a check, two
// child reads, a select and a compare per child pair going down, then a
// closing check and a step that writes the entry into its slot, over up to
// 11 levels through one-read-port heap and deadline memories. Dequeue first
// fetches the last slot's entry and deadline; activate of a queued entry
// passes a reorder step before its walk. Refill computes its two 32x32
// partial products and saturating sums, then stores the deadline or starts
// the walk. After reset busy stays high while the queued-flag memory is cleared.
module wfq_deadline_ready_heap_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  wdrh_pkg::req_t request,
  output logic           done,
  output wdrh_pkg::rsp_t result
);

  wdrh_pkg::cmd_t cmd;
  wdrh_pkg::sts_t sts;

  wdrh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  wdrh_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .sts     (sts),
    .result  (result)
  );

endmodule
